// File: rtl/trs_pkg.sv
// Package for the text reply sanitizer: widths, character codes and the
// result and push structures shared by the core, the queue and the top level.
// No dependencies.
package trs_pkg;

    localparam int MAX_CAPACITY = 4096;
    localparam int CAP_W        = 13;
    localparam int LEN_W        = 12;
    localparam int WORD_W       = 8;
    localparam int CHAR_W       = 8;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [CAP_W-1:0] CAP_CLAMP = CAP_W'(MAX_CAPACITY);

    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_GRAVE = 8'h60;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 13'd256;
    localparam logic [WORD_W-1:0] WORD_RESET = 8'd20;

    typedef enum logic [0:0] {
        REG_CAPACITY   = 1'b0,
        REG_WORD_LIMIT = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [CHAR_W-1:0] char_value;
        logic              is_char;
        logic              success;
        logic [LEN_W-1:0]  out_length;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// File: rtl/trs_core.sv
// Sanitizer core: per-string state and the single-pass byte classification
// that yields zero, one or two results per item. Uses trs_pkg.
module trs_core
    import trs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [CHAR_W-1:0] i_byte,
    input  logic              i_eos,
    input  logic [CAP_W-1:0]  i_cap,
    input  logic [WORD_W-1:0] i_limit,
    output t_push             o_push
);

    logic [LEN_W-1:0]  r_len, n_len;
    logic [WORD_W-1:0] r_words, n_words;
    logic              r_inside, n_inside;
    logic              r_after, n_after;
    logic              r_pend, n_pend;
    logic              r_stop, n_stop;
    logic              r_fail, n_fail;

    logic              is_markup;
    logic              is_ws;
    logic              is_ctrl;
    logic              go;
    logic              emit_sp;
    logic [LEN_W-1:0]  len_mid;
    logic [CHAR_W-1:0] low_char;
    t_result           sp_res;
    t_result           ch_res;

    assign is_markup = (i_byte == CH_STAR) || (i_byte == CH_UNDER) ||
                       (i_byte == CH_GRAVE) || (i_byte == CH_HASH) ||
                       (i_byte == CH_GT) || (i_byte == CH_TILDE) ||
                       (i_byte == CH_PIPE);
    assign is_ws   = ((i_byte >= CH_TAB) && (i_byte <= CH_CR)) || (i_byte == CH_SPACE);
    assign is_ctrl = (i_byte < CH_SPACE) || (i_byte == CH_DEL);
    assign low_char = ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_Z)) ?
                      (i_byte | CASE_BIT) : i_byte;

    always_comb begin
        n_len    = r_len;
        n_words  = r_words;
        n_inside = r_inside;
        n_after  = r_after;
        n_pend   = r_pend;
        n_stop   = r_stop;
        n_fail   = r_fail;
        go       = 1'b0;
        emit_sp  = 1'b0;
        len_mid  = r_len;
        sp_res   = '{char_value: CH_SPACE, is_char: 1'b1, success: 1'b0,
                     out_length: '0, last: 1'b0};
        ch_res   = '{char_value: low_char, is_char: 1'b1, success: 1'b0,
                     out_length: '0, last: 1'b1};
        o_push   = '0;
        if (i_fire) begin
            if (i_eos) begin
                o_push.num   = 2'd1;
                o_push.first = '{char_value: '0, is_char: 1'b0,
                                 success: (!r_fail && (r_len != '0)),
                                 out_length: r_len, last: 1'b1};
                n_len    = '0;
                n_words  = '0;
                n_inside = 1'b0;
                n_after  = 1'b1;
                n_pend   = 1'b0;
                n_stop   = 1'b0;
                n_fail   = 1'b0;
            end else if (!r_stop && !r_fail && !i_byte[CHAR_W-1] && !is_markup) begin
                if (is_ws) begin
                    if (!r_after) begin
                        n_pend = 1'b1;
                    end
                    n_after  = 1'b1;
                    n_inside = 1'b0;
                end else if (!is_ctrl) begin
                    go = 1'b1;
                    if (!r_inside) begin
                        if (r_words >= i_limit) begin
                            n_stop = 1'b1;
                            n_pend = 1'b0;
                            go     = 1'b0;
                        end else begin
                            n_words  = r_words + 1'b1;
                            n_inside = 1'b1;
                        end
                    end
                    if (go) begin
                        if (r_pend) begin
                            n_pend = 1'b0;
                            if (({1'b0, r_len} + 1'b1) < i_cap) begin
                                len_mid = r_len + 1'b1;
                                emit_sp = 1'b1;
                            end
                        end
                        n_len = len_mid;
                        if (({1'b0, len_mid} + 1'b1) >= i_cap) begin
                            n_fail = 1'b1;
                            if (emit_sp) begin
                                sp_res.last  = 1'b1;
                                o_push.num   = 2'd1;
                                o_push.first = sp_res;
                            end
                        end else begin
                            n_len   = len_mid + 1'b1;
                            n_after = 1'b0;
                            if (emit_sp) begin
                                o_push.num    = 2'd2;
                                o_push.first  = sp_res;
                                o_push.second = ch_res;
                            end else begin
                                o_push.num   = 2'd1;
                                o_push.first = ch_res;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_words  <= '0;
            r_inside <= 1'b0;
            r_after  <= 1'b1;
            r_pend   <= 1'b0;
            r_stop   <= 1'b0;
            r_fail   <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_words  <= n_words;
            r_inside <= n_inside;
            r_after  <= n_after;
            r_pend   <= n_pend;
            r_stop   <= n_stop;
            r_fail   <= n_fail;
        end
    end

endmodule

// File: rtl/trs_outq.sv
// Result queue of four entries that takes up to two results per cycle and
// hands out one per cycle while the reader is ready. Uses trs_pkg.
module trs_outq
    import trs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop_ready,
    output logic    o_room2,
    output logic    o_valid,
    output t_result o_head
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;
    logic [QPTR_W-1:0] wr_next;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room2 = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign pop     = o_valid && i_pop_ready;
    assign wr_next = r_wr + 1'b1;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.num);
        n_rd  = pop ? (r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push.num) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/text_reply_sanitizer_unit.sv
// Top level of the text reply sanitizer: configuration registers, input
// register, core and result queue. Uses trs_pkg, trs_core and trs_outq.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: byte_value; tlast: end_of_string
//   m_axis   out        tdata: char_value, success, out_length; tuser: is_char;
//                       tlast: last
//   cfg      in         index, 13-bit data; always ready
//
// One input request is taken per cycle while s_axis tready is high. It is
// held in the input register, and its results wait in the result queue.
// An item with a pending space yields two results while only one leaves per
// cycle, so the input register holds whenever fewer than two of the four
// result queue entries are free. Reset is synchronous and active low and
// restores capacity 256 and word limit 20. A stalled output fills the queue
// and then holds the input register, which drops s_axis tready.
module text_reply_sanitizer_unit
    import trs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] char_value, [8] success,
                                        // [20:9] out_length, [23:21] zero
    output logic        m_axis_tuser,   // [0] is_char
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic [CAP_W-1:0]  r_capacity;
    logic [WORD_W-1:0] r_limit;
    logic              r_in_valid, n_in_valid;
    logic [CHAR_W-1:0] r_in_byte;
    logic              r_in_eos;
    logic [CAP_W-1:0]  cap_eff;
    logic              room2;
    logic              proc;
    logic              s_fire;
    t_push             push;
    t_result           head;

    assign o_cfg_ready   = 1'b1;
    assign cap_eff       = (r_capacity > CAP_CLAMP) ? CAP_CLAMP : r_capacity;
    assign proc          = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || proc;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign n_in_valid    = s_fire ? 1'b1 : (proc ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_limit    <= WORD_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_index'(i_cfg_index))
                REG_CAPACITY:   r_capacity <= i_cfg_data;
                REG_WORD_LIMIT: r_limit    <= i_cfg_data[WORD_W-1:0];
                default:        r_limit    <= r_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_byte <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    trs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .i_cap   (cap_eff),
        .i_limit (r_limit),
        .o_push  (push)
    );

    trs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (m_axis_tready),
        .o_room2     (room2),
        .o_valid     (m_axis_tvalid),
        .o_head      (head)
    );

    assign m_axis_tdata = {3'b000, head.out_length, head.success, head.char_value};
    assign m_axis_tuser = head.is_char;
    assign m_axis_tlast = head.last;

`ifndef SYNTH
    a_completion_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("completion result without tlast");

    a_char_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[20:8] == 13'd0))
        else $error("character result carries status fields");

    a_eos_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_eos) |=> m_axis_tvalid)
        else $error("end marker produced no completion");
`endif

endmodule

// File: verif/tb_text_reply_sanitizer_unit.sv
// Self-checking testbench for text_reply_sanitizer_unit: directed and random byte strings with stalls on
// both streams, a built-in model of the sanitizer and in-order result checking.
// Depends on trs_pkg and the text_reply_sanitizer_unit RTL.
`timescale 1ns / 1ps

module tb_text_reply_sanitizer_unit;
    import trs_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASE_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic [7:0] value;
        logic       closes;
    } t_text_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_reg_index  i_cfg_index = REG_CAPACITY;
    logic [12:0] i_cfg_data = '0;

    t_text_beat  byte_stream[$];
    t_result     expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned items_queued = 0;

    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    int unsigned hold_left = 0;
    logic        src_steady = 1'b0;
    logic        sink_steady = 1'b0;
    int unsigned stall_kick = 0;
    int unsigned stall_kick_seen = 0;

    // Shadow of the block: registers and per-string state.
    logic [CAP_W-1:0]  cfg_capacity = CAP_RESET;
    logic [WORD_W-1:0] cfg_word_limit = WORD_RESET;
    int unsigned       written_len = 0;
    int unsigned       words_kept = 0;
    logic              in_word = 1'b0;
    logic              after_blank = 1'b1;
    logic              blank_pending = 1'b0;
    logic              cut_off = 1'b0;
    logic              overflowed = 1'b0;

    text_reply_sanitizer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void clear_string();
        written_len   = 0;
        words_kept    = 0;
        in_word       = 1'b0;
        after_blank   = 1'b1;
        blank_pending = 1'b0;
        cut_off       = 1'b0;
        overflowed    = 1'b0;
    endfunction

    function automatic void predict_sanitized(logic [7:0] b, logic closes);
        int unsigned room;
        t_result     r;
        t_result     blank;
        logic        has_blank;
        room = (cfg_capacity > CAP_CLAMP) ? MAX_CAPACITY : cfg_capacity;
        has_blank = 1'b0;
        r = '0;
        blank = '0;
        if (closes) begin
            r.success    = !overflowed && written_len != 0;
            r.out_length = written_len[LEN_W-1:0];
            r.last       = 1'b1;
            expected_results.push_back(r);
            clear_string();
            return;
        end
        if (cut_off || overflowed || b[7]) return;
        if (b == CH_STAR || b == CH_UNDER || b == CH_GRAVE || b == CH_HASH ||
            b == CH_GT || b == CH_TILDE || b == CH_PIPE) return;
        if ((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE) begin
            if (!after_blank) blank_pending = 1'b1;
            after_blank = 1'b1;
            in_word     = 1'b0;
            return;
        end
        if (b < CH_SPACE || b == CH_DEL) return;
        if (!in_word) begin
            if (words_kept >= cfg_word_limit) begin
                cut_off       = 1'b1;
                blank_pending = 1'b0;
                return;
            end
            words_kept++;
            in_word = 1'b1;
        end
        if (blank_pending) begin
            blank_pending = 1'b0;
            if (written_len + 1 < room) begin
                written_len++;
                blank.char_value = CH_SPACE;
                blank.is_char    = 1'b1;
                has_blank        = 1'b1;
            end
        end
        if (written_len + 1 >= room) begin
            overflowed = 1'b1;
            if (has_blank) begin
                blank.last = 1'b1;
                expected_results.push_back(blank);
            end
            return;
        end
        if (has_blank) expected_results.push_back(blank);
        r.char_value = (b >= CH_UP_A && b <= CH_UP_Z) ? (b | CASE_BIT) : b;
        r.is_char    = 1'b1;
        r.last       = 1'b1;
        written_len++;
        after_blank = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void flag_mismatch(string why, t_result want, t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected char %h is_char %b success %b len %0d last %b",
                     why, want.char_value, want.is_char, want.success, want.out_length,
                     want.last);
            $display("    got char %h is_char %b success %b len %0d last %b",
                     got.char_value, got.is_char, got.success, got.out_length, got.last);
        end
    endfunction

    always @(posedge i_clk) begin : drive_bytes
        t_text_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sanitized(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait != 0) begin
                    src_wait      <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_stream.size() != 0) begin
                    nxt = byte_stream.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.value;
                    s_axis_tlast  <= nxt.closes;
                    src_wait      <= src_steady ? 0 : draw_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : pace_sink
        if (stall_kick != stall_kick_seen) begin
            stall_kick_seen <= stall_kick;
            hold_left       <= LONG_HOLD;
            m_axis_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait     <= sink_wait - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!sink_steady && $urandom_range(0, 3) == 0) sink_wait <= draw_gap();
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.char_value = m_axis_tdata[7:0];
            got.success    = m_axis_tdata[8];
            got.out_length = m_axis_tdata[20:9];
            got.is_char    = m_axis_tuser;
            got.last       = m_axis_tlast;
            if (expected_results.size() == 0) begin
                flag_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.char_value !== want.char_value || got.is_char !== want.is_char ||
                    got.success !== want.success || got.out_length !== want.out_length ||
                    got.last !== want.last) begin
                    flag_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    task automatic queue_byte(logic [7:0] b);
        byte_stream.push_back('{value: b, closes: 1'b0});
        items_queued++;
    endtask

    task automatic queue_end();
        byte_stream.push_back('{value: 8'($urandom_range(0, 255)), closes: 1'b1});
        items_queued++;
    endtask

    function automatic logic [7:0] pick_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] pick_text();
        return ($urandom_range(0, 9) < 7) ? pick_letter() : 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] pick_junk();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 6))
                    0: return CH_STAR;
                    1: return CH_UNDER;
                    2: return CH_GRAVE;
                    3: return CH_HASH;
                    4: return CH_GT;
                    5: return CH_TILDE;
                    default: return CH_PIPE;
                endcase
            end
            1: return $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(14, 31));
            2: return CH_DEL;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    task automatic queue_blanks();
        repeat ($urandom_range(1, 3)) begin
            queue_byte(($urandom_range(0, 5) == 5) ? CH_SPACE : 8'($urandom_range(9, 13)));
        end
    endtask

    task automatic queue_random_string(int unsigned word_cap);
        int unsigned kind;
        int unsigned nwords;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(0, 16)) queue_byte(8'($urandom_range(0, 255)));
        end else if (kind == 1) begin
            repeat ($urandom_range(0, 3)) queue_byte(pick_letter());
        end else begin
            if ($urandom_range(0, 3) == 0) queue_blanks();
            nwords = $urandom_range(0, (word_cap + 3 > 12) ? 12 : word_cap + 3);
            for (int w = 0; w < nwords; w++) begin
                if (w != 0) queue_blanks();
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 9) == 0) queue_byte(pick_junk());
                    queue_byte(pick_text());
                end
            end
            if ($urandom_range(0, 2) == 0) queue_blanks();
        end
        queue_end();
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
        queue_end();
    endtask

    task automatic write_register(t_reg_index idx, logic [12:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_CAPACITY:   cfg_capacity = value;
            REG_WORD_LIMIT: cfg_word_limit = value[WORD_W-1:0];
            default:        cfg_word_limit = cfg_word_limit;
        endcase
    endtask

    task automatic configure(logic [12:0] capacity, logic [7:0] word_limit);
        write_register(REG_CAPACITY, capacity);
        write_register(REG_WORD_LIMIT, {5'd0, word_limit});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_stream.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_start;
        logic [12:0] capacity;
        logic [7:0]  word_limit;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: markup, control, high bytes, case folding and blank handling.
        queue_byte(CH_SPACE);
        queue_byte("H");
        queue_byte("Z");
        queue_byte(CH_TAB);
        queue_byte(CH_CR);
        queue_byte(CH_STAR);
        queue_byte(CH_UNDER);
        queue_byte(CH_GRAVE);
        queue_byte(CH_HASH);
        queue_byte(CH_GT);
        queue_byte(CH_TILDE);
        queue_byte(CH_PIPE);
        queue_byte(8'h00);
        queue_byte(CH_DEL);
        queue_byte(8'hFF);
        queue_byte("a");
        queue_byte(CH_SPACE);
        queue_end();
        queue_end();
        wait_idle();

        // A pending blank with no room is dropped; one that fits goes out alone.
        write_register(REG_CAPACITY, 13'd3);
        queue_text("ab c");
        wait_idle();
        write_register(REG_CAPACITY, 13'd4);
        queue_text("ab c");
        wait_idle();

        items_queued = 0;
        phase = 0;
        while (items_queued < RANDOM_ITEMS) begin
            case (phase)
                0: begin capacity = 13'd0;    word_limit = 8'd255; end
                1: begin capacity = 13'd1;    word_limit = 8'd0;   end
                2: begin capacity = 13'd4096; word_limit = 8'd255; end
                3: begin capacity = 13'd256;  word_limit = 8'd20;  end
                4: begin capacity = 13'd2;    word_limit = 8'd1;   end
                default: begin
                    case ($urandom_range(0, 9))
                        0: capacity = 13'($urandom_range(0, 8191));
                        1, 2: capacity = 13'($urandom_range(41, 300));
                        default: capacity = 13'($urandom_range(1, 40));
                    endcase
                    word_limit = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8))
                                                            : 8'($urandom_range(0, 255));
                end
            endcase
            configure(capacity, word_limit);
            src_steady  <= (phase == 3) || ($urandom_range(0, 5) == 0);
            sink_steady <= ($urandom_range(0, 5) == 0);
            if (phase == 3) stall_kick <= stall_kick + 1;
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) queue_random_string(word_limit);
            wait_idle();
            phase++;
        end

        if (expected_results.size() != 0) begin
            mismatch_count += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/trs_pkg.sv
rtl/trs_core.sv
rtl/trs_outq.sv
rtl/text_reply_sanitizer_unit.sv
verif/tb_text_reply_sanitizer_unit.sv
